/* design/assert_macros.svh */
// Assertion helpers shared by the design files.
// Every check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/kcdd_pkg.sv */
`default_nettype none

package kcdd_pkg;

    // Number of key lines in one sampled word.
    localparam int KEY_LINES = 4;
    // Number of fixed combination codes.
    localparam int CODE_SLOTS = 6;
    // Width of the reported slot index.
    localparam int CODE_SLOT_BITS = 3;
    // Width of each configuration register.
    localparam int CFG_DATA_BITS = 16;
    // Width of the configuration register index.
    localparam int CFG_INDEX_BITS = 1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE_TICKS   = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLD_LIMIT_TICKS = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [CFG_DATA_BITS-1:0] DEBOUNCE_TICKS_RESET   = 16'd20;
    localparam logic [CFG_DATA_BITS-1:0] HOLD_LIMIT_TICKS_RESET = 16'd3000;

    typedef logic [KEY_LINES-1:0] pattern_t;

    // The combination codes, searched from slot 0 upward.
    localparam pattern_t COMBO_CODES [CODE_SLOTS] = '{
        4'h1, 4'h2, 4'h4, 4'h8, 4'h5, 4'hC
    };

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_WAIT     = 2'd2
    } phase_t;

    typedef struct packed {
        logic                      matched;
        logic [CODE_SLOT_BITS-1:0] slot;
    } lookup_t;

    typedef struct packed {
        pattern_t                  pattern;
        logic                      matched;
        logic [CODE_SLOT_BITS-1:0] slot;
        logic                      timeout;
    } result_t;

    // Finds the first combination code equal to the pattern.
    function automatic lookup_t code_lookup(input pattern_t pattern);
        lookup_t res;
        res.matched = 1'b0;
        res.slot    = '0;
        for (int i = 0; i < CODE_SLOTS; i++)
        begin
            if (!res.matched && (pattern == COMBO_CODES[i]))
            begin
                res.matched = 1'b1;
                res.slot    = CODE_SLOT_BITS'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* design/key_combo_debounce_detector_top.sv */
`default_nettype none
`include "assert_macros.svh"

// Key combination debouncer. Each accepted input word is one time tick carrying
// the sampled key lines. A nonzero pattern is captured and must stay unchanged
// for debounce_ticks ticks; after that the block waits for the pattern to change
// (release included) or for hold_limit_ticks ticks to pass, and then emits one
// output word with the held pattern, whether it equals one of the six fixed
// combination codes (and which slot), and whether the hold ended by timeout.
// The phase machine, the saturating tick counter and the code compares all sit
// between the state registers and the output register, so a new word is accepted
// every cycle while in_stall is low. Results pass through an output register
// backed by a one-word skid register; in_stall rises only while that skid
// register is occupied, which happens only when the downstream side stalls.
// Configuration registers may be written whenever no word is in flight.
module key_combo_debounce_detector_top #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // Input channel.
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [kcdd_pkg::KEY_LINES-1:0]         keys_pressed,
    // Output channel.
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic [kcdd_pkg::KEY_LINES-1:0]              pressed_pattern,
    output logic                                        code_matched,
    output logic [kcdd_pkg::CODE_SLOT_BITS-1:0]         code_slot,
    output logic                                        ended_by_timeout,
    // Configuration write port.
    input  wire logic                                   cfg_write,
    input  wire logic [kcdd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [kcdd_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    import kcdd_pkg::*;

    // Compare width wide enough for both the counter and the registers.
    localparam int CMP_BITS = (TIMER_BITS > CFG_DATA_BITS) ? TIMER_BITS : CFG_DATA_BITS;

    logic [CFG_DATA_BITS-1:0] debounce_reg;
    logic [CFG_DATA_BITS-1:0] hold_limit_reg;

    phase_t                phase_reg;
    phase_t                phase_next;
    pattern_t              held_reg;
    pattern_t              held_next;
    logic [TIMER_BITS-1:0] elapsed_reg;
    logic [TIMER_BITS-1:0] elapsed_next;

    logic                  in_accept;
    logic [TIMER_BITS-1:0] elapsed_inc;
    logic                  keys_changed;
    logic                  debounce_done;
    logic                  hold_done;
    logic                  fire;
    logic                  fire_timeout;
    lookup_t               lookup;
    result_t               result;

    logic                  out_valid_reg;
    result_t               out_reg;
    logic                  skid_valid_reg;
    result_t               skid_reg;
    logic                  out_take;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_TICKS_RESET;
            hold_limit_reg <= HOLD_LIMIT_TICKS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DEBOUNCE_TICKS:   debounce_reg   <= cfg_data;
                CFG_HOLD_LIMIT_TICKS: hold_limit_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !in_stall;

    // The counter saturates at its all-ones value.
    assign elapsed_inc   = (elapsed_reg == {TIMER_BITS{1'b1}}) ? elapsed_reg
                                                               : elapsed_reg + 1'b1;
    assign keys_changed  = (keys_pressed != held_reg);
    // A register value of zero passes at once, since the raised count is at least one.
    assign debounce_done = (CMP_BITS'(elapsed_inc) >= CMP_BITS'(debounce_reg));
    assign hold_done     = (CMP_BITS'(elapsed_inc) >= CMP_BITS'(hold_limit_reg));

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (in_accept)
        begin
            case (phase_reg)
                PH_DEBOUNCE:
                begin
                    if (keys_changed)
                        phase_next = PH_IDLE;
                    else if (debounce_done)
                        phase_next = PH_WAIT;
                end
                PH_WAIT:
                begin
                    if (keys_changed || hold_done)
                        phase_next = PH_IDLE;
                end
                default:
                begin
                    // The unused phase code behaves as idle.
                    phase_next = (keys_pressed != '0) ? PH_DEBOUNCE : PH_IDLE;
                end
            endcase
        end
    end

    // Datapath and event outputs of the phase machine.
    always_comb
    begin
        held_next    = held_reg;
        elapsed_next = elapsed_reg;
        fire         = 1'b0;
        fire_timeout = 1'b0;
        if (in_accept)
        begin
            case (phase_reg)
                PH_DEBOUNCE:
                begin
                    if (keys_changed)
                    begin
                        held_next    = '0;
                        elapsed_next = '0;
                    end
                    else if (debounce_done)
                        elapsed_next = '0;
                    else
                        elapsed_next = elapsed_inc;
                end
                PH_WAIT:
                begin
                    if (keys_changed)
                    begin
                        fire         = 1'b1;
                        held_next    = '0;
                        elapsed_next = '0;
                    end
                    else if (hold_done)
                    begin
                        fire         = 1'b1;
                        fire_timeout = 1'b1;
                        held_next    = '0;
                        elapsed_next = '0;
                    end
                    else
                        elapsed_next = elapsed_inc;
                end
                default:
                begin
                    held_next    = keys_pressed;
                    elapsed_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            held_reg    <= '0;
            elapsed_reg <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            held_reg    <= held_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // The event describes the pattern that was being held.
    assign lookup         = code_lookup(held_reg);
    assign result.pattern = held_reg;
    assign result.matched = lookup.matched;
    assign result.slot    = lookup.slot;
    assign result.timeout = fire_timeout;

    // Output register with a one-word skid register behind it.
    assign out_take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (fire)
        begin
            if (out_valid_reg && !out_take)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_reg <= skid_reg;
        end
        else if (fire)
        begin
            if (out_valid_reg && !out_take)
                skid_reg <= result;
            else
                out_reg <= result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign pressed_pattern  = out_reg.pattern;
    assign code_matched     = out_reg.matched;
    assign code_slot        = out_reg.slot;
    assign ended_by_timeout = out_reg.timeout;

    // The skid register only fills behind a full output register.
    `ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_reg || out_valid_reg,
        "skid word present without an output word")
    // A held pattern exists exactly when the machine is not idle.
    `ASSERT_ALWAYS(a_held_matches_phase, (phase_reg == PH_IDLE) == (held_reg == '0),
        "held pattern disagrees with phase")
    // Every event sends the machine back to idle.
    `ASSERT_NEXT(a_event_to_idle, fire, phase_reg == PH_IDLE,
        "machine not idle after an event")

endmodule

`default_nettype wire

/* test/tb_key_combo_debounce_detector_top.sv */
`default_nettype none

// Testbench for the key combination debouncer.
// Every accepted input word is one tick of the key lines. A predictor in this file tracks
// the phase, the held pattern and the elapsed count and queues the event that each tick
// causes. The checker pops the oldest queued event for every accepted output word.
module tb_key_combo_debounce_detector_top;
    import kcdd_pkg::*;

    localparam int TICK_BITS       = 16;
    localparam logic [TICK_BITS-1:0] TICKS_MAX = '1;
    // After the last event has left, a tick that caused no event may still sit in the
    // phase registers. The settle wait covers that with room to spare.
    localparam int SETTLE_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PRESSURE_CYCLES = 300;
    localparam int RANDOM_PHASES   = 7;
    localparam int WORDS_PER_PHASE = 200;
    localparam int REPORT_LIMIT    = 10;
    // A press at the maximum debounce time that is released long before it counts.
    localparam int LONG_PRESS_WORDS = 30;

    // Each directed row is either a run of identical words or a register write.
    typedef enum logic [1:0] {
        ROW_WORD,
        ROW_DEBOUNCE,
        ROW_HOLD
    } row_kind_t;

    typedef struct packed {
        row_kind_t       kind;
        logic [15:0]     value;
        logic [3:0]      reps;
        logic            typed;
        result_t         want;
    } stim_row_t;

    // The typed events are read straight off the rules: with one-tick debounce and hold a
    // pattern held for three words times out, and the slot follows the code order.
    localparam int DIRECTED_ROWS = 19;
    localparam stim_row_t DIRECTED_STIM [DIRECTED_ROWS] = '{
        '{ROW_DEBOUNCE, 16'd1,  4'd0, 1'b0, '0},
        '{ROW_HOLD,     16'd1,  4'd0, 1'b0, '0},
        '{ROW_WORD,     16'h0,  4'd2, 1'b0, '0},
        '{ROW_WORD,     16'h1,  4'd3, 1'b1, {4'h1, 1'b1, 3'd0, 1'b1}},
        '{ROW_WORD,     16'h2,  4'd3, 1'b1, {4'h2, 1'b1, 3'd1, 1'b1}},
        '{ROW_WORD,     16'h4,  4'd3, 1'b1, {4'h4, 1'b1, 3'd2, 1'b1}},
        '{ROW_WORD,     16'h8,  4'd3, 1'b1, {4'h8, 1'b1, 3'd3, 1'b1}},
        '{ROW_WORD,     16'h5,  4'd3, 1'b1, {4'h5, 1'b1, 3'd4, 1'b1}},
        '{ROW_WORD,     16'hC,  4'd3, 1'b1, {4'hC, 1'b1, 3'd5, 1'b1}},
        '{ROW_WORD,     16'hF,  4'd3, 1'b1, {4'hF, 1'b0, 3'd0, 1'b1}},
        '{ROW_WORD,     16'h3,  4'd1, 1'b0, '0},
        '{ROW_WORD,     16'h6,  4'd1, 1'b0, '0},
        '{ROW_WORD,     16'h6,  4'd2, 1'b0, '0},
        '{ROW_WORD,     16'h7,  4'd1, 1'b1, {4'h6, 1'b0, 3'd0, 1'b0}},
        '{ROW_WORD,     16'h9,  4'd2, 1'b0, '0},
        '{ROW_WORD,     16'h0,  4'd1, 1'b1, {4'h9, 1'b0, 3'd0, 1'b0}},
        '{ROW_DEBOUNCE, 16'd0,  4'd0, 1'b0, '0},
        '{ROW_HOLD,     16'd0,  4'd0, 1'b0, '0},
        '{ROW_WORD,     16'hA,  4'd3, 1'b1, {4'hA, 1'b0, 3'd0, 1'b1}}
    };

    logic                        clk;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [KEY_LINES-1:0]        keys_pressed = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [KEY_LINES-1:0]        pressed_pattern;
    logic                        code_matched;
    logic [CODE_SLOT_BITS-1:0]   code_slot;
    logic                        ended_by_timeout;
    logic                        cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0]   cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]    cfg_data = '0;

    key_combo_debounce_detector_top DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .keys_pressed     (keys_pressed),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .pressed_pattern  (pressed_pattern),
        .code_matched     (code_matched),
        .code_slot        (code_slot),
        .ended_by_timeout (ended_by_timeout),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // Predictor state: a private copy of the registers and of the phase machine.
    logic [CFG_DATA_BITS-1:0] debounce_cfg = DEBOUNCE_TICKS_RESET;
    logic [CFG_DATA_BITS-1:0] hold_cfg     = HOLD_LIMIT_TICKS_RESET;
    phase_t                   key_phase    = PH_IDLE;
    pattern_t                 held_keys    = '0;
    logic [TICK_BITS-1:0]     elapsed_count = '0;

    result_t expected_events [$];

    // Knobs that the stimulus flow sets per phase and the two idling processes read.
    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;
    bit hold_off_request = 1'b0;

    int words_sent      = 0;
    int events_checked  = 0;
    int timeout_events  = 0;
    int mismatch_count  = 0;
    int reg_writes      = 0;
    int full_cycles     = 0;
    int quiet_cycles    = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // One tick of the debouncer. Returns 1 when the tick closes a hold and fills in the
    // event that the block has to report.
    function automatic bit debounce_tick(input pattern_t keys, output result_t ev);
        bit fire;
        bit timeout;
        fire = 1'b0;
        timeout = 1'b0;
        ev = '0;
        case (key_phase)
            PH_DEBOUNCE:
            begin
                if (elapsed_count != TICKS_MAX)
                    elapsed_count++;
                if (keys != held_keys)
                begin
                    key_phase = PH_IDLE;
                    held_keys = '0;
                    elapsed_count = '0;
                end
                else if (elapsed_count >= debounce_cfg)
                begin
                    key_phase = PH_WAIT;
                    elapsed_count = '0;
                end
            end
            PH_WAIT:
            begin
                if (keys != held_keys)
                    fire = 1'b1;
                else
                begin
                    if (elapsed_count != TICKS_MAX)
                        elapsed_count++;
                    if (elapsed_count >= hold_cfg)
                    begin
                        fire = 1'b1;
                        timeout = 1'b1;
                    end
                end
            end
            default:
            begin
                // Any nonzero pattern starts a debounce; an all-released word keeps idle.
                held_keys = keys;
                elapsed_count = '0;
                key_phase = (keys != '0) ? PH_DEBOUNCE : PH_IDLE;
            end
        endcase
        if (fire)
        begin
            ev.pattern = held_keys;
            ev.timeout = timeout;
            // The first code in slot order that equals the held pattern wins.
            for (int i = 0; i < CODE_SLOTS; i++)
            begin
                if (!ev.matched && held_keys == COMBO_CODES[i])
                begin
                    ev.matched = 1'b1;
                    ev.slot = CODE_SLOT_BITS'(i);
                end
            end
            key_phase = PH_IDLE;
            held_keys = '0;
            elapsed_count = '0;
        end
        return fire;
    endfunction

    // Idle stretch lengths: mostly short, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offers one word and returns at the edge where it is accepted. The valid line is
    // left high, so back-to-back words need no extra assignment at that edge.
    task automatic send_word(input pattern_t keys, input bit typed, input result_t typed_ev);
        int gap;
        result_t ev;
        bit fire;
        gap = 0;
        if (send_idle && $urandom_range(0, 99) >= 55)
            gap = idle_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        keys_pressed <= keys;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
        fire = debounce_tick(keys, ev);
        if (typed)
            expected_events.push_back(typed_ev);
        else if (fire)
            expected_events.push_back(ev);
    endtask

    // Stops offering words, waits for every queued event, then lets the last tick
    // settle so that a register write cannot land on a word still in the block.
    task automatic drain_block();
        in_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes one register and lowers the enable again; the task then waits so that a
    // following write never meets a lowering in the same step.
    task automatic set_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_DEBOUNCE_TICKS)
            debounce_cfg = value;
        else
            hold_cfg = value;
        reg_writes++;
        @(posedge clk);
    endtask

    // One stretch of random stimulus. Most stretches are proper key presses that get
    // through debounce and end by release, by a changed pattern or by timeout; the rest
    // are presses that bounce away early and plain noise on the key lines.
    task automatic play_sequence();
        int kind;
        int debounce_eff;
        int span;
        int count;
        pattern_t pick;
        result_t none;
        none = '0;
        kind = $urandom_range(0, 9);
        debounce_eff = (debounce_cfg == 0) ? 1 : int'(debounce_cfg);
        if (kind < 7)
        begin
            pick = $urandom_range(0, 1) ? COMBO_CODES[$urandom_range(0, CODE_SLOTS - 1)]
                                        : pattern_t'($urandom_range(1, 15));
            span = (hold_cfg > 39) ? 40 : int'(hold_cfg) + 1;
            count = 1 + debounce_eff + $urandom_range(0, span);
            repeat (count) send_word(pick, 1'b0, none);
            if ($urandom_range(0, 2) == 0)
                send_word(pick ^ pattern_t'($urandom_range(1, 15)), 1'b0, none);
            else
                repeat ($urandom_range(1, 3)) send_word('0, 1'b0, none);
        end
        else if (kind == 7)
        begin
            // Held for no more than the debounce time, so it never counts as pressed.
            pick = pattern_t'($urandom_range(1, 15));
            count = $urandom_range(1, debounce_eff);
            repeat (count) send_word(pick, 1'b0, none);
            send_word(pick ^ pattern_t'($urandom_range(1, 15)), 1'b0, none);
        end
        else
        begin
            repeat ($urandom_range(1, 4)) send_word(pattern_t'($urandom_range(0, 15)), 1'b0, none);
        end
    endtask

    // Receiver: random stall stretches, a long hold-off on request, or no stalls at all.
    // Exactly one assignment to out_stall happens at any edge.
    initial
    begin
        forever
        begin
            if (hold_off_request)
            begin
                out_stall <= 1'b1;
                repeat (PRESSURE_CYCLES) @(posedge clk);
                hold_off_request = 1'b0;
            end
            else if (recv_idle && $urandom_range(0, 99) < 35)
            begin
                out_stall <= 1'b1;
                repeat (idle_length()) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
        end
    end

    // Checker: every accepted output word is compared with the oldest queued event.
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {pressed_pattern, code_matched, code_slot, ended_by_timeout};
            events_checked++;
            if (ended_by_timeout)
                timeout_events++;
            if (expected_events.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("Unexpected event: pattern %h matched %b slot %0d timeout %b",
                             got.pattern, got.matched, got.slot, got.timeout);
            end
            else
            begin
                want = expected_events.pop_front();
                if (got.pattern != want.pattern || got.matched != want.matched ||
                    got.slot != want.slot || got.timeout != want.timeout)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"Event mismatch: expected pattern %h matched %b slot %0d ",
                                  "timeout %b, got pattern %h matched %b slot %0d timeout %b"},
                                 want.pattern, want.matched, want.slot, want.timeout,
                                 got.pattern, got.matched, got.slot, got.timeout);
                end
            end
        end
    end

    // Watchdog: cycles in which no word moves on either side are counted; a lost event
    // or a hung handshake ends the run here.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_stall)
            full_cycles++;
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired with %0d events outstanding.", expected_events.size());
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: every combination code, a nonmatching full pattern, a bounce
        // that breaks debounce, a changed pattern, a release, and zero registers.
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            case (DIRECTED_STIM[r].kind)
                ROW_DEBOUNCE:
                begin
                    drain_block();
                    set_register(CFG_DEBOUNCE_TICKS, DIRECTED_STIM[r].value);
                end
                ROW_HOLD:
                begin
                    drain_block();
                    set_register(CFG_HOLD_LIMIT_TICKS, DIRECTED_STIM[r].value);
                end
                default:
                begin
                    // The typed event belongs to the last word of the run.
                    for (int k = 1; k <= int'(DIRECTED_STIM[r].reps); k++)
                        send_word(pattern_t'(DIRECTED_STIM[r].value),
                                  DIRECTED_STIM[r].typed && k == int'(DIRECTED_STIM[r].reps),
                                  DIRECTED_STIM[r].want);
                end
            endcase
        end

        // Random part: one register setting per phase. Phase 0 returns to the reset
        // values, phase 5 draws its own, and the last one runs the hold-off that fills
        // the block while words keep coming.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            int start_words;
            logic [CFG_DATA_BITS-1:0] next_debounce;
            logic [CFG_DATA_BITS-1:0] next_hold;
            case (ph)
                0:
                begin
                    next_debounce = DEBOUNCE_TICKS_RESET;
                    next_hold     = HOLD_LIMIT_TICKS_RESET;
                end
                1:
                begin
                    next_debounce = 16'd1;
                    next_hold     = 16'd1;
                end
                2:
                begin
                    next_debounce = 16'd3;
                    next_hold     = 16'd7;
                end
                3:
                begin
                    next_debounce = 16'd0;
                    next_hold     = 16'd4;
                end
                4:
                begin
                    next_debounce = 16'd5;
                    next_hold     = 16'hFFFF;
                end
                5:
                begin
                    next_debounce = CFG_DATA_BITS'($urandom_range(1, 12));
                    next_hold     = CFG_DATA_BITS'($urandom_range(1, 30));
                end
                default:
                begin
                    next_debounce = 16'd1;
                    next_hold     = 16'd1;
                end
            endcase
            drain_block();
            set_register(CFG_DEBOUNCE_TICKS, next_debounce);
            set_register(CFG_HOLD_LIMIT_TICKS, next_hold);
            send_idle = (ph % 3 != 1);
            recv_idle = (ph % 3 != 2);
            if (ph == RANDOM_PHASES - 1)
            begin
                send_idle = 1'b0;
                hold_off_request = 1'b1;
            end
            start_words = words_sent;
            while (words_sent - start_words < WORDS_PER_PHASE)
                play_sequence();
        end

        // Both registers at their maximum: a press far shorter than the debounce time
        // never reaches wait-for-release, so its release gives no event.
        drain_block();
        set_register(CFG_DEBOUNCE_TICKS, 16'hFFFF);
        set_register(CFG_HOLD_LIMIT_TICKS, 16'hFFFF);
        send_idle = 1'b0;
        recv_idle = 1'b1;
        repeat (LONG_PRESS_WORDS) send_word(4'h5, 1'b0, '0);
        repeat (2) send_word('0, 1'b0, '0);

        drain_block();
        $display("Sent %0d words under %0d register writes; checked %0d events, %0d by timeout.",
                 words_sent, reg_writes, events_checked, timeout_events);
        $display("Input stalled by a full block for %0d cycles; %0d mismatches.",
                 full_cycles, mismatch_count);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
